>>> rtl/core/terminal_input_escape_decoder_core_macros.svh
// Assertion macros shared by the checker of the terminal input decoder.
`ifndef TERMINAL_INPUT_ESCAPE_DECODER_CORE_MACROS_SVH
`define TERMINAL_INPUT_ESCAPE_DECODER_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TIED_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define TIED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tied_pkg.sv
// Package of the terminal input decoder: types, codes and the tilde key table.
`timescale 1ns / 1ps
package tied_pkg;

    localparam int MAX_PARAMS  = 6;
    localparam int PARAM_WIDTH = 16;
    localparam int IDX_W       = $clog2(MAX_PARAMS);

    typedef enum logic [2:0] {
        MODE_GROUND, MODE_UTF8, MODE_ESC, MODE_SS3, MODE_CSI_START, MODE_CSI_PARAM
    } t_mode;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_NAMED = 2'd1;
    localparam logic [1:0] KIND_MOUSE = 2'd2;

    localparam logic [4:0] KEY_UP     = 5'd0;
    localparam logic [4:0] KEY_DOWN   = 5'd1;
    localparam logic [4:0] KEY_RIGHT  = 5'd2;
    localparam logic [4:0] KEY_LEFT   = 5'd3;
    localparam logic [4:0] KEY_HOME   = 5'd4;
    localparam logic [4:0] KEY_END    = 5'd5;
    localparam logic [4:0] KEY_BTAB   = 5'd6;
    localparam logic [4:0] KEY_INS    = 5'd7;
    localparam logic [4:0] KEY_DEL    = 5'd8;
    localparam logic [4:0] KEY_PGUP   = 5'd9;
    localparam logic [4:0] KEY_PGDN   = 5'd10;
    localparam logic [4:0] KEY_F1     = 5'd11;
    localparam logic [4:0] KEY_ESCAPE = 5'd23;

    localparam logic [2:0] MOD_NONE  = 3'd0;
    localparam logic [2:0] MOD_SHIFT = 3'd1;
    localparam logic [2:0] MOD_ALT   = 3'd2;
    localparam logic [2:0] MOD_CTRL  = 3'd4;

    localparam logic [2:0] BTN_PRIMARY   = 3'd0;
    localparam logic [2:0] BTN_AUX       = 3'd1;
    localparam logic [2:0] BTN_SECONDARY = 3'd2;
    localparam logic [2:0] BTN_WHUP      = 3'd3;
    localparam logic [2:0] BTN_WHDN      = 3'd4;
    localparam logic [2:0] BTN_MOVE      = 3'd5;

    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_DRAG    = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_O     = 8'h4f;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_M_UP  = 8'h4d;
    localparam logic [7:0] CH_M_LO  = 8'h6d;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_Q = 8'h51;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_Z = 8'h5a;

    typedef struct packed {
        logic signed [16:0] mouse_y;
        logic signed [16:0] mouse_x;
        logic [1:0]  mouse_action;
        logic [2:0]  mouse_button;
        logic [2:0]  modifiers;
        logic [4:0]  named_key;
        logic [20:0] char_code;
        logic [1:0]  event_kind;
    } t_event;

    // Handshake from the output stage back to the queue.
    typedef struct packed {
        logic pop;
    } t_q_ctl;

    // Key for a '~' sequence; valid low when the code is unknown.
    function automatic logic [5:0] tilde_key(input logic [PARAM_WIDTH-1:0] p);
        logic [5:0] r;
        r = 6'd0;
        case (p)
            PARAM_WIDTH'(1):  r = {1'b1, KEY_HOME};
            PARAM_WIDTH'(2):  r = {1'b1, KEY_INS};
            PARAM_WIDTH'(3):  r = {1'b1, KEY_DEL};
            PARAM_WIDTH'(4):  r = {1'b1, KEY_END};
            PARAM_WIDTH'(5):  r = {1'b1, KEY_PGUP};
            PARAM_WIDTH'(6):  r = {1'b1, KEY_PGDN};
            PARAM_WIDTH'(11): r = {1'b1, KEY_F1};
            PARAM_WIDTH'(12): r = {1'b1, KEY_F1 + 5'd1};
            PARAM_WIDTH'(13): r = {1'b1, KEY_F1 + 5'd2};
            PARAM_WIDTH'(14): r = {1'b1, KEY_F1 + 5'd3};
            PARAM_WIDTH'(15): r = {1'b1, KEY_F1 + 5'd4};
            PARAM_WIDTH'(17): r = {1'b1, KEY_F1 + 5'd5};
            PARAM_WIDTH'(18): r = {1'b1, KEY_F1 + 5'd6};
            PARAM_WIDTH'(19): r = {1'b1, KEY_F1 + 5'd7};
            PARAM_WIDTH'(20): r = {1'b1, KEY_F1 + 5'd8};
            PARAM_WIDTH'(21): r = {1'b1, KEY_F1 + 5'd9};
            PARAM_WIDTH'(23): r = {1'b1, KEY_F1 + 5'd10};
            PARAM_WIDTH'(24): r = {1'b1, KEY_F1 + 5'd11};
            default:          r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/tied_front.sv
// Front end: parses bytes and ticks and produces decoded events.
`timescale 1ns / 1ps
module tied_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_op,
    input  logic [7:0]           i_byte,
    input  logic [15:0]          i_timeout,
    output logic                 o_push,
    output tied_pkg::t_event     o_event
);

    localparam int PW = tied_pkg::PARAM_WIDTH;
    localparam int IW = tied_pkg::IDX_W;

    tied_pkg::t_mode r_mode, n_mode;
    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_rem, n_rem;
    logic [PW-1:0] r_par [tied_pkg::MAX_PARAMS];
    logic [PW-1:0] n_par [tied_pkg::MAX_PARAMS];
    logic [IW-1:0] r_idx, n_idx;
    logic        r_sgr, n_sgr;
    logic [15:0] r_cnt, n_cnt;

    logic [15:0]   cnt_inc;
    logic [PW+3:0] digit_sum;
    logic [PW-1:0] digit_sat;
    logic [20:0]   acc_shift;
    logic          is_digit;

    assign cnt_inc   = (r_cnt == 16'hffff) ? r_cnt : r_cnt + 16'd1;
    assign digit_sum = ({4'd0, r_par[r_idx]} << 3) + ({4'd0, r_par[r_idx]} << 1)
                     + {{PW{1'b0}}, i_byte[3:0]};
    assign digit_sat = (digit_sum[PW+3:PW] != 4'd0) ? {PW{1'b1}} : digit_sum[PW-1:0];
    assign acc_shift = {r_acc[14:0], i_byte[5:0]};
    assign is_digit  = (i_byte >= tied_pkg::CH_ZERO) && (i_byte <= tied_pkg::CH_NINE);

    // Next state.
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_par  = r_par;
        n_idx  = r_idx;
        n_sgr  = r_sgr;
        n_cnt  = r_cnt;
        if (i_take) begin
            if (i_op) begin
                if (r_mode == tied_pkg::MODE_ESC) begin
                    if (cnt_inc >= i_timeout) begin
                        n_mode = tied_pkg::MODE_GROUND;
                        n_cnt  = 16'd0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end else begin
                unique case (r_mode)
                    tied_pkg::MODE_UTF8: begin
                        n_acc = acc_shift;
                        n_rem = (r_rem != 2'd0) ? r_rem - 2'd1 : r_rem;
                        if (r_rem <= 2'd1) n_mode = tied_pkg::MODE_GROUND;
                    end
                    tied_pkg::MODE_ESC: begin
                        n_cnt = 16'd0;
                        if (i_byte == tied_pkg::CH_O) begin
                            n_mode = tied_pkg::MODE_SS3;
                        end else if (i_byte == tied_pkg::CH_LBRK) begin
                            n_mode = tied_pkg::MODE_CSI_START;
                            for (int k = 0; k < tied_pkg::MAX_PARAMS; k++) n_par[k] = '0;
                            n_idx = '0;
                            n_sgr = 1'b0;
                        end else begin
                            n_mode = tied_pkg::MODE_GROUND;
                        end
                    end
                    tied_pkg::MODE_SS3: n_mode = tied_pkg::MODE_GROUND;
                    tied_pkg::MODE_CSI_START, tied_pkg::MODE_CSI_PARAM: begin
                        n_mode = tied_pkg::MODE_CSI_PARAM;
                        if (r_mode == tied_pkg::MODE_CSI_START && i_byte == tied_pkg::CH_LT) begin
                            n_sgr = 1'b1;
                        end else if (i_byte == tied_pkg::CH_SEMI) begin
                            if (r_idx < IW'(tied_pkg::MAX_PARAMS - 1)) n_idx = r_idx + 1'b1;
                        end else if (is_digit) begin
                            n_par[r_idx] = digit_sat;
                        end else begin
                            n_mode = tied_pkg::MODE_GROUND;
                        end
                    end
                    default: begin
                        if (i_byte == tied_pkg::CH_ESC) begin
                            n_mode = tied_pkg::MODE_ESC;
                            n_cnt  = 16'd0;
                        end else if (i_byte[7]) begin
                            n_mode = tied_pkg::MODE_UTF8;
                            if (i_byte[7:5] == 3'b110) begin
                                n_acc = {16'd0, i_byte[4:0]};
                                n_rem = 2'd1;
                            end else if (i_byte[7:4] == 4'b1110) begin
                                n_acc = {17'd0, i_byte[3:0]};
                                n_rem = 2'd2;
                            end else begin
                                n_acc = {18'd0, i_byte[2:0]};
                                n_rem = 2'd3;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Event output.
    always_comb begin
        logic [PW-1:0] b;
        logic [5:0]    tk;
        logic [4:0]    key;
        logic          key_ok;
        b      = r_par[0];
        tk     = tied_pkg::tilde_key(r_par[0]);
        key    = tied_pkg::KEY_UP;
        key_ok = 1'b0;
        o_push  = 1'b0;
        o_event = '0;
        if (i_take) begin
            if (i_op) begin
                if (r_mode == tied_pkg::MODE_ESC && cnt_inc >= i_timeout) begin
                    o_push = 1'b1;
                    o_event.event_kind = tied_pkg::KIND_NAMED;
                    o_event.named_key  = tied_pkg::KEY_ESCAPE;
                end
            end else begin
                unique case (r_mode)
                    tied_pkg::MODE_UTF8: begin
                        if (r_rem <= 2'd1) begin
                            o_push = 1'b1;
                            o_event.char_code = acc_shift;
                        end
                    end
                    tied_pkg::MODE_ESC: begin
                        if (i_byte != tied_pkg::CH_O && i_byte != tied_pkg::CH_LBRK) begin
                            o_push = 1'b1;
                            o_event.char_code = {13'd0, i_byte};
                            o_event.modifiers = tied_pkg::MOD_ALT;
                        end
                    end
                    tied_pkg::MODE_SS3: begin
                        key_ok = 1'b1;
                        case (i_byte)
                            tied_pkg::CH_A: key = tied_pkg::KEY_UP;
                            tied_pkg::CH_B: key = tied_pkg::KEY_DOWN;
                            tied_pkg::CH_C: key = tied_pkg::KEY_RIGHT;
                            tied_pkg::CH_D: key = tied_pkg::KEY_LEFT;
                            tied_pkg::CH_H: key = tied_pkg::KEY_HOME;
                            tied_pkg::CH_F: key = tied_pkg::KEY_END;
                            tied_pkg::CH_P: key = tied_pkg::KEY_F1;
                            tied_pkg::CH_Q: key = tied_pkg::KEY_F1 + 5'd1;
                            tied_pkg::CH_R: key = tied_pkg::KEY_F1 + 5'd2;
                            tied_pkg::CH_S: key = tied_pkg::KEY_F1 + 5'd3;
                            default:        key_ok = 1'b0;
                        endcase
                        o_push = key_ok;
                        o_event.event_kind = tied_pkg::KIND_NAMED;
                        o_event.named_key  = key;
                    end
                    tied_pkg::MODE_CSI_START, tied_pkg::MODE_CSI_PARAM: begin
                        if (!(r_mode == tied_pkg::MODE_CSI_START && i_byte == tied_pkg::CH_LT)
                                && i_byte != tied_pkg::CH_SEMI && !is_digit) begin
                            if (r_sgr && (i_byte == tied_pkg::CH_M_UP
                                          || i_byte == tied_pkg::CH_M_LO)) begin
                                o_push = 1'b1;
                                o_event.event_kind = tied_pkg::KIND_MOUSE;
                                o_event.modifiers  = {b[4], b[3], b[2]};
                                if (b[6]) begin
                                    o_event.mouse_button = (b[1:0] == 2'd0) ?
                                        tied_pkg::BTN_WHUP : tied_pkg::BTN_WHDN;
                                    o_event.mouse_action = tied_pkg::ACT_PRESS;
                                end else if (b[5] && b[1:0] == 2'd3) begin
                                    o_event.mouse_button = tied_pkg::BTN_MOVE;
                                    o_event.mouse_action = tied_pkg::ACT_DRAG;
                                end else begin
                                    o_event.mouse_button =
                                        (b[1:0] == 2'd0) ? tied_pkg::BTN_PRIMARY :
                                        (b[1:0] == 2'd1) ? tied_pkg::BTN_AUX :
                                        tied_pkg::BTN_SECONDARY;
                                    o_event.mouse_action =
                                        (i_byte == tied_pkg::CH_M_LO) ? tied_pkg::ACT_RELEASE :
                                        b[5] ? tied_pkg::ACT_DRAG : tied_pkg::ACT_PRESS;
                                end
                                o_event.mouse_x = 17'({1'b0, r_par[1]} - 17'd1);
                                o_event.mouse_y = 17'({1'b0, r_par[2]} - 17'd1);
                            end else begin
                                key_ok = 1'b1;
                                case (i_byte)
                                    tied_pkg::CH_A: key = tied_pkg::KEY_UP;
                                    tied_pkg::CH_B: key = tied_pkg::KEY_DOWN;
                                    tied_pkg::CH_C: key = tied_pkg::KEY_RIGHT;
                                    tied_pkg::CH_D: key = tied_pkg::KEY_LEFT;
                                    tied_pkg::CH_H: key = tied_pkg::KEY_HOME;
                                    tied_pkg::CH_F: key = tied_pkg::KEY_END;
                                    tied_pkg::CH_Z: key = tied_pkg::KEY_BTAB;
                                    tied_pkg::CH_TILDE: begin
                                        key    = tk[4:0];
                                        key_ok = tk[5];
                                    end
                                    default: key_ok = 1'b0;
                                endcase
                                o_push = key_ok;
                                o_event.event_kind = tied_pkg::KIND_NAMED;
                                o_event.named_key  = key;
                                o_event.modifiers  = (r_idx != '0) ?
                                    3'(r_par[1] - PW'(1)) : tied_pkg::MOD_NONE;
                            end
                        end
                    end
                    default: begin
                        if (i_byte == tied_pkg::CH_ESC || i_byte == tied_pkg::CH_NUL) begin
                            o_push = 1'b0;
                        end else if (i_byte < tied_pkg::CH_SPACE && i_byte != tied_pkg::CH_CR
                                     && i_byte != tied_pkg::CH_TAB && i_byte != tied_pkg::CH_LF) begin
                            o_push = 1'b1;
                            o_event.char_code = {13'd0, i_byte + 8'h60};
                            o_event.modifiers = tied_pkg::MOD_CTRL;
                        end else if (i_byte == tied_pkg::CH_LF) begin
                            o_push = 1'b1;
                            o_event.char_code = {13'd0, tied_pkg::CH_CR};
                        end else if (!i_byte[7]) begin
                            o_push = 1'b1;
                            o_event.char_code = {13'd0, i_byte};
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tied_pkg::MODE_GROUND;
            r_acc  <= '0;
            r_rem  <= '0;
            for (int k = 0; k < tied_pkg::MAX_PARAMS; k++) r_par[k] <= '0;
            r_idx  <= '0;
            r_sgr  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_par  <= n_par;
            r_idx  <= n_idx;
            r_sgr  <= n_sgr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

>>> rtl/core/tied_queue.sv
// Two-entry event queue between the parser and the output stage.
`timescale 1ns / 1ps
module tied_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tied_pkg::t_event i_event,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nempty,
    output tied_pkg::t_event o_event
);

    tied_pkg::t_event r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_event  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> rtl/core/tied_back.sv
// Back end: output register that presents events on the result stream.
`timescale 1ns / 1ps
module tied_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_nempty,
    input  tied_pkg::t_event i_event,
    output tied_pkg::t_q_ctl o_ctl,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [71:0]      o_data
);

    logic             r_valid;
    tied_pkg::t_event r_data;
    logic             load;

    assign load         = i_q_nempty && (!r_valid || i_ready);
    assign o_ctl.pop    = load;
    assign o_valid      = r_valid;
    assign o_data       = {2'b00, r_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_data <= i_event;
    end

endmodule

>>> rtl/core/terminal_input_escape_decoder_core.sv
// Top level of the terminal input escape decoder.
`timescale 1ns / 1ps
// Decodes a stream of raw terminal bytes and timer ticks into key and mouse
// events. Each input transfer carries either a byte (tuser low) or one tick
// (tuser high), and gives at most one event transfer. The parser updates its
// state in the cycle the transfer is accepted, so a new item is taken every
// cycle while the queue has a free entry; a result passes through the event
// queue register and then the output register. A two-entry queue separates
// the parser from the output register, so the input keeps flowing while a
// result waits to be taken and stalls only once both queue entries are held.
// A lone ESC is reported as the Escape key once esc_timeout_ticks ticks have
// passed; the register sits at APB address 0 and resets to 40. Configuration
// should only be written while no transfer is in flight.
module terminal_input_escape_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] event_kind, [22:2] char_code, [27:23] named_key, [30:28] modifiers,
    // [33:31] mouse_button, [35:34] mouse_action, [52:36] mouse_x, [69:53] mouse_y
    output logic [71:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]      r_timeout;
    logic             take;
    logic             push;
    logic             q_full;
    tied_pkg::t_event ev_front;
    tied_pkg::t_event ev_queue;
    tied_pkg::t_q_ctl q_ctl;
    logic             q_nempty;

    // Configuration register: one 16-bit timeout, read at byte address 0 and written at any address with paddr[2] low.
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd40;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_timeout <= pwdata[15:0];
        end
    end

    // The input is held only while the queue has no free entry.
    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && s_axis_tready;

    tied_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_op      (s_axis_tuser),
        .i_byte    (s_axis_tdata),
        .i_timeout (r_timeout),
        .o_push    (push),
        .o_event   (ev_front)
    );

    tied_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_event  (ev_front),
        .o_full   (q_full),
        .i_pop    (q_ctl.pop),
        .o_nempty (q_nempty),
        .o_event  (ev_queue)
    );

    tied_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (q_nempty),
        .i_event    (ev_queue),
        .o_ctl      (q_ctl),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

>>> rtl/core/tied_checker.sv
// Port-level checker for the terminal input decoder, bound to the top level.
`timescale 1ns / 1ps
`include "terminal_input_escape_decoder_core_macros.svh"
module tied_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        pready
);

    `TIED_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `TIED_ASSERT(a_kind_legal, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3, "illegal event kind")
    `TIED_ASSERT(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[71:70] == 2'b00, "padding bits set")
    `TIED_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid && pready, "output valid after reset")

endmodule

bind terminal_input_escape_decoder_core tied_checker u_tied_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
